### hw/rtl/ictab_pkg.sv
// Shared types and constants for the per-context instruction count table.
`timescale 1ns / 1ps
`default_nettype none
package ictab_pkg;

  localparam int          TABLE_ENTRIES_DEF = 64;
  localparam logic [63:0] MIN_ASID_RST      = 64'd10;

  typedef enum logic [1:0] {
    OP_SWITCH    = 2'd0,
    OP_QUERY_ID  = 2'd1,
    OP_QUERY_CUR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_SCAN,
    S_FIN,
    S_OUT
  } state_t;

  // operands for the shared add / compare unit
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic        inv;
    logic        cin;
    logic [63:0] tag;
    logic [63:0] key;
  } alu_req_t;

  typedef struct packed {
    logic tag_we;
    logic fac_we;
  } mem_wen_t;

endpackage
`default_nettype wire

### hw/rtl/ictab_alu.sv
// Shared 64-bit adder and tag comparator used by the table sequencer.
`timescale 1ns / 1ps
`default_nettype none
module ictab_alu import ictab_pkg::*; (
  input  alu_req_t    req,
  output logic [63:0] sum,
  output logic        eq
);

  logic [63:0] b_op;

  // a + ~b gives a - 1 - b; with carry in it is a - b
  assign b_op = req.inv ? ~req.b : req.b;
  assign sum  = req.a + b_op + {63'd0, req.cin};
  assign eq   = (req.tag == req.key);

endmodule
`default_nettype wire

### hw/rtl/ictab_mem.sv
// Tag and factor storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ictab_mem import ictab_pkg::*; #(
  parameter int ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                       clk,
  input  mem_wen_t                   wen,
  input  logic [$clog2(ENTRIES)-1:0] waddr,
  input  logic [63:0]                wtag,
  input  logic [63:0]                wfac,
  input  logic                       re,
  input  logic [$clog2(ENTRIES)-1:0] raddr,
  output logic [63:0]                rtag,
  output logic [63:0]                rfac
);

  logic [63:0] tag_mem [ENTRIES];
  logic [63:0] fac_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wen.tag_we) begin
      tag_mem[waddr] <= wtag;
    end
    if (wen.fac_we) begin
      fac_mem[waddr] <= wfac;
    end
    if (re) begin
      rtag <= tag_mem[raddr];
      rfac <= fac_mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/per_context_instr_count_table.sv
// Per-context instruction count table: top level with sequencer and valid bits.
//
// Usage: items enter on in_t* (operation, old/new/query ASID, global count) and
// results leave on out_t* (corrected count, status). cfg_valid/cfg_data writes
// min_asid; cfg_ready is always high and writes belong to idle periods.
// Paths: a switch below min_asid, a switch to the same ID and the unused
// operation go from accept through S_DEC and S_OUT to the output register.
// A switch that updates the table and both queries walk the whole table
// through one memory read port, one entry per cycle, via S_DEC, S_SCAN, S_FIN
// and S_OUT.
// One item is in flight at a time; in_tready is high only while idle.
// The result sits in an output register, so the next item is taken while a
// result still waits; if the receiver stalls longer, the finished item waits
// in the sequencer until the output register frees up.
// Reset clears the valid bits, interval start, current ID and min_asid (10);
// tag and factor memories need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module per_context_instr_count_table import ictab_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: operation[1:0], from_asid[65:2], to_asid[129:66],
  //           query_asid[193:130], instr_count[257:194], zero pad[263:258]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [263:0] in_tdata,
  // out_tdata: corrected_count[63:0], status[65:64], zero pad[71:66]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [63:0]  cfg_data
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_END = CW'(TABLE_ENTRIES);

  state_t state_r, state_nxt;

  logic [1:0]  op_r, op_nxt;
  logic [63:0] old_r, old_nxt;
  logic [63:0] new_r, new_nxt;
  logic [63:0] q_r, q_nxt;
  logic [63:0] now_r, now_nxt;
  logic [63:0] key_r, key_nxt;
  logic [63:0] len_r, len_nxt;
  logic [63:0] istart_r, istart_nxt;
  logic [63:0] active_r, active_nxt;
  logic [63:0] min_r, min_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          found_r, found_nxt;
  logic [63:0]   fac_hit_r, fac_hit_nxt;
  logic          free_found_r, free_found_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic [63:0]   res_cnt_r, res_cnt_nxt;
  status_t       res_st_r, res_st_nxt;
  logic          out_vld_r, out_vld_nxt;
  logic [71:0]   out_data_r, out_data_nxt;

  alu_req_t      alu_req;
  logic [63:0]   alu_sum;
  logic          alu_eq;
  mem_wen_t      wen;
  logic [IW-1:0] waddr;
  logic [63:0]   wtag;
  logic [63:0]   wfac;
  logic          re;
  logic [IW-1:0] raddr;
  logic [63:0]   rtag;
  logic [63:0]   rfac;
  logic [IW-1:0] chk_idx;
  logic          vbit;

  ictab_alu u_alu (
    .req (alu_req),
    .sum (alu_sum),
    .eq  (alu_eq)
  );

  ictab_mem #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_mem (
    .clk   (clk),
    .wen   (wen),
    .waddr (waddr),
    .wtag  (wtag),
    .wfac  (wfac),
    .re    (re),
    .raddr (raddr),
    .rtag  (rtag),
    .rfac  (rfac)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  // read data in the scan belongs to the entry issued in the previous cycle
  assign chk_idx = IW'(cnt_r - 1'b1);
  assign vbit    = valid_r[chk_idx];

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    old_nxt        = old_r;
    new_nxt        = new_r;
    q_nxt          = q_r;
    now_nxt        = now_r;
    key_nxt        = key_r;
    len_nxt        = len_r;
    istart_nxt     = istart_r;
    active_nxt     = active_r;
    min_nxt        = cfg_valid ? cfg_data : min_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    found_nxt      = found_r;
    fac_hit_nxt    = fac_hit_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    res_cnt_nxt    = res_cnt_r;
    res_st_nxt     = res_st_r;
    out_vld_nxt    = out_vld_r & ~out_tready;
    out_data_nxt   = out_data_r;

    alu_req.a   = now_r;
    alu_req.b   = istart_r;
    alu_req.inv = 1'b1;
    alu_req.cin = 1'b0;
    alu_req.tag = rtag;
    alu_req.key = key_r;

    wen.tag_we = 1'b0;
    wen.fac_we = 1'b0;
    waddr      = chk_idx;
    wtag       = key_r;
    wfac       = alu_sum;
    re         = 1'b0;
    raddr      = cnt_r[IW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tdata[1:0];
          old_nxt   = in_tdata[65:2];
          new_nxt   = in_tdata[129:66];
          q_nxt     = in_tdata[193:130];
          now_nxt   = in_tdata[257:194];
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        res_cnt_nxt    = 64'd0;
        res_st_nxt     = ST_DONE;
        cnt_nxt        = '0;
        found_nxt      = 1'b0;
        free_found_nxt = 1'b0;
        free_idx_nxt   = '0;
        case (op_t'(op_r))
          OP_SWITCH: begin
            if (new_r < min_r) begin
              res_st_nxt = ST_IGNORED;
              state_nxt  = S_OUT;
            end else if (old_r == new_r) begin
              istart_nxt = now_r;
              active_nxt = new_r;
              state_nxt  = S_OUT;
            end else begin
              // interval length: now - 1 - interval start
              len_nxt   = alu_sum;
              key_nxt   = old_r;
              state_nxt = S_SCAN;
            end
          end
          OP_QUERY_ID: begin
            key_nxt   = q_r;
            state_nxt = S_SCAN;
          end
          OP_QUERY_CUR: begin
            key_nxt   = active_r;
            state_nxt = S_SCAN;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end

      S_SCAN: begin
        re          = (cnt_r < CNT_END);
        cnt_nxt     = cnt_r + 1'b1;
        alu_req.a   = rfac;
        alu_req.b   = len_r;
        alu_req.inv = 1'b0;
        if (cnt_r != '0) begin
          if ((op_t'(op_r) == OP_SWITCH) && vbit && !alu_eq) begin
            wen.fac_we = 1'b1;
          end
          if (vbit && alu_eq) begin
            found_nxt   = 1'b1;
            fac_hit_nxt = rfac;
          end
          if (!vbit && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx;
          end
          if (cnt_r == CNT_END) begin
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        alu_req.a   = now_r;
        alu_req.b   = fac_hit_r;
        alu_req.inv = 1'b1;
        alu_req.cin = 1'b1;
        waddr       = free_idx_r;
        wfac        = (op_t'(op_r) == OP_SWITCH) ? now_r : 64'd0;
        if (found_r) begin
          res_cnt_nxt = (op_t'(op_r) == OP_SWITCH) ? 64'd0 : alu_sum;
        end else begin
          res_cnt_nxt = (op_t'(op_r) == OP_SWITCH) ? 64'd0 : now_r;
          if (free_found_r) begin
            valid_nxt[free_idx_r] = 1'b1;
            wen.tag_we            = 1'b1;
            wen.fac_we            = 1'b1;
          end else begin
            res_st_nxt = ST_FULL;
          end
        end
        if (op_t'(op_r) == OP_SWITCH) begin
          istart_nxt = now_r;
          active_nxt = new_r;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {6'd0, res_st_r, res_cnt_r};
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      istart_r  <= 64'd0;
      active_r  <= 64'd0;
      min_r     <= MIN_ASID_RST;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      istart_r  <= istart_nxt;
      active_r  <= active_nxt;
      min_r     <= min_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    old_r        <= old_nxt;
    new_r        <= new_nxt;
    q_r          <= q_nxt;
    now_r        <= now_nxt;
    key_r        <= key_nxt;
    len_r        <= len_nxt;
    cnt_r        <= cnt_nxt;
    found_r      <= found_nxt;
    fac_hit_r    <= fac_hit_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    res_cnt_r    <= res_cnt_nxt;
    res_st_r     <= res_st_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule
`default_nettype wire
